/* design/websocket_frame_deframer_top_assert.svh */
// Assertion macros for the WebSocket frame deframer checker
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WSDF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define WSDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/wsdf_pkg.sv */
// Types and constants shared by the WebSocket frame deframer modules
package wsdf_pkg;

    localparam logic [7:0] OPCODE_MASK = 8'h0F;
    localparam logic [7:0] MASK_BIT    = 8'h80;
    localparam logic [7:0] LEN7_MASK   = 8'h7F;
    localparam logic [6:0] LEN7_EXT16  = 7'd126;
    localparam logic [6:0] LEN7_EXT64  = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    typedef enum logic [4:0] {
        PH_HDR0    = 5'b00001,
        PH_HDR1    = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } in_word_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       has_byte;
        logic       frame_last;
    } result_t;

endpackage

/* design/websocket_frame_deframer_top.sv */
// WebSocket frame deframer top level
//
// Input channel (s_valid/s_ready/s_rx_byte) carries the received stream,
// one word per byte. Header bytes (opcode byte, length byte, extended
// length, mask key) produce no result. Each payload byte produces one
// result on the m_ channel: the unmasked byte, the frame opcode, has_byte
// set, and frame_last on the final byte. A zero-length frame produces one
// marker result with has_byte clear and frame_last set.
// A byte is taken into the input register, then passes through the
// parser into the result register once that register is empty or its
// result is being taken. Throughput: one byte per cycle while m_ready is high; the parser step is a
// single combinational pass between the two registers.
// When m_ready is low with a result held, an empty input register still
// takes one byte, then s_ready drops until the result is taken.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to the first header byte with the opcode, key and length cleared.
module websocket_frame_deframer_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic [3:0] m_frame_opcode,
    output logic       m_has_byte,
    output logic       m_frame_last
);
    import wsdf_pkg::*;

    in_word_t word;
    result_t  res;
    logic     advance;

    assign advance = word.vld && (!m_valid || m_ready);

    wsdf_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .word      (word)
    );

    wsdf_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .word    (word),
        .res     (res)
    );

    wsdf_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .res            (res),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_frame_opcode (m_frame_opcode),
        .m_has_byte     (m_has_byte),
        .m_frame_last   (m_frame_last)
    );

endmodule

/* design/wsdf_in_stage.sv */
// Input register for received bytes
module wsdf_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               advance,
    output wsdf_pkg::in_word_t word
);
    import wsdf_pkg::*;

    logic       vld_reg, vld_next;
    logic [7:0] data_reg, data_next;

    assign s_ready = !vld_reg || advance;

    always_comb begin
        vld_next  = vld_reg;
        data_next = data_reg;
        if (s_valid && s_ready) begin
            vld_next  = 1'b1;
            data_next = s_rx_byte;
        end else if (advance) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        data_reg <= data_next;
    end

    assign word.vld  = vld_reg;
    assign word.data = data_reg;

endmodule

/* design/wsdf_parser.sv */
// Frame header parser and payload unmasking
module wsdf_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  wsdf_pkg::in_word_t word,
    output wsdf_pkg::result_t  res
);
    import wsdf_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_on_reg, mask_on_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [31:0] key_reg, key_next;
    logic [2:0]  key_left_reg, key_left_next;
    logic [63:0] remain_reg, remain_next;
    logic [1:0]  offset_reg, offset_next;

    logic [7:0]  b;
    logic [6:0]  len7;
    logic [7:0]  key_byte;
    logic        len_done;
    logic        begin_pl;
    logic        mask_sel;
    logic [63:0] len_val;

    assign b = word.data;

    always_comb begin
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        mask_on_next  = mask_on_reg;
        len_left_next = len_left_reg;
        key_next      = key_reg;
        key_left_next = key_left_reg;
        remain_next   = remain_reg;
        offset_next   = offset_reg;
        len7          = b[6:0] & LEN7_MASK[6:0];
        len_done      = 1'b0;
        begin_pl      = 1'b0;
        mask_sel      = mask_on_reg;
        len_val       = remain_reg;
        key_byte      = 8'h00;
        res           = '0;
        res.frame_opcode = opcode_reg;

        case (phase_reg)
            PH_HDR1: begin
                mask_sel     = |(b & MASK_BIT);
                mask_on_next = mask_sel;
                remain_next  = '0;
                if (len7 == LEN7_EXT16) begin
                    len_left_next = EXT16_BYTES;
                    phase_next    = PH_EXTLEN;
                end else if (len7 == LEN7_EXT64) begin
                    len_left_next = EXT64_BYTES;
                    phase_next    = PH_EXTLEN;
                end else begin
                    remain_next = {57'd0, len7};
                    len_done    = 1'b1;
                end
            end
            PH_EXTLEN: begin
                remain_next = {remain_reg[55:0], b};
                if (len_left_reg != 4'd0) begin
                    len_left_next = len_left_reg - 4'd1;
                end
                if (len_left_next == 4'd0) begin
                    len_done = 1'b1;
                end
            end
            PH_KEY: begin
                key_next = {key_reg[23:0], b};
                if (key_left_reg != 3'd0) begin
                    key_left_next = key_left_reg - 3'd1;
                end
                if (key_left_next == 3'd0) begin
                    begin_pl = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                if (mask_on_reg) begin
                    case (offset_reg)
                        2'd0:    key_byte = key_reg[31:24];
                        2'd1:    key_byte = key_reg[23:16];
                        2'd2:    key_byte = key_reg[15:8];
                        default: key_byte = key_reg[7:0];
                    endcase
                end
                offset_next = offset_reg + 2'd1;
                if (remain_reg != 64'd0) begin
                    remain_next = remain_reg - 64'd1;
                end
                res.emit         = 1'b1;
                res.payload_byte = b ^ key_byte;
                res.has_byte     = 1'b1;
                res.frame_last   = (remain_next == 64'd0);
                if (remain_next == 64'd0) begin
                    phase_next = PH_HDR0;
                end
            end
            default: begin
                opcode_next = b[3:0] & OPCODE_MASK[3:0];
                phase_next  = PH_HDR1;
            end
        endcase

        len_val = remain_next;
        if (len_done) begin
            if (mask_sel) begin
                key_next      = '0;
                key_left_next = KEY_BYTES;
                phase_next    = PH_KEY;
            end else begin
                begin_pl = 1'b1;
            end
        end

        if (begin_pl) begin
            offset_next = 2'd0;
            if (len_val == 64'd0) begin
                phase_next     = PH_HDR0;
                res.emit       = 1'b1;
                res.frame_last = 1'b1;
            end else begin
                phase_next = PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR0;
            opcode_reg   <= '0;
            mask_on_reg  <= 1'b0;
            len_left_reg <= '0;
            key_reg      <= '0;
            key_left_reg <= '0;
            remain_reg   <= '0;
            offset_reg   <= '0;
        end else if (advance && word.vld) begin
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            mask_on_reg  <= mask_on_next;
            len_left_reg <= len_left_next;
            key_reg      <= key_next;
            key_left_reg <= key_left_next;
            remain_reg   <= remain_next;
            offset_reg   <= offset_next;
        end
    end

endmodule

/* design/wsdf_out_stage.sv */
// Result register for the result channel
module wsdf_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  wsdf_pkg::result_t res,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_payload_byte,
    output logic [3:0]        m_frame_opcode,
    output logic              m_has_byte,
    output logic              m_frame_last
);
    import wsdf_pkg::*;

    logic    vld_reg, vld_next;
    result_t res_reg, res_next;

    always_comb begin
        vld_next = vld_reg;
        res_next = res_reg;
        if (advance) begin
            vld_next = res.emit;
            res_next = res;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        res_reg <= res_next;
    end

    assign m_valid        = vld_reg;
    assign m_payload_byte = res_reg.payload_byte;
    assign m_frame_opcode = res_reg.frame_opcode;
    assign m_has_byte     = res_reg.has_byte;
    assign m_frame_last   = res_reg.frame_last;

endmodule

/* design/wsdf_checker.sv */
// Port-level checker for the WebSocket frame deframer, bound to the top level
`include "websocket_frame_deframer_top_assert.svh"

module wsdf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_rx_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_payload_byte,
    input logic [3:0] m_frame_opcode,
    input logic       m_has_byte,
    input logic       m_frame_last
);

    logic        marker;
    logic        zero_byte;
    logic        s_stall;
    logic        m_stall;
    logic [13:0] m_word;

    assign marker    = m_valid && !m_has_byte;
    assign zero_byte = (m_payload_byte == 8'h00);
    assign s_stall   = s_valid && !s_ready;
    assign m_stall   = m_valid && !m_ready;
    assign m_word    = {m_payload_byte, m_frame_opcode, m_has_byte, m_frame_last};

    `WSDF_ASSERT_IMPL(a_marker_last, marker, m_frame_last && zero_byte, "bad empty-frame marker")
    `WSDF_ASSERT_IMPL(a_ready_follows, m_ready, s_ready, "input stalled while result side ready")
    `WSDF_ASSERT_IMPL(a_reset_empty, $past(!aresetn), !m_valid, "result right after reset")
    `WSDF_ASSERT_NEXT(a_hold, m_stall, m_valid && $stable(m_word), "stalled result changed")
    `WSDF_ASSERT_NEXT(a_in_hold, s_stall, s_valid && $stable(s_rx_byte), "stalled input changed")

endmodule

bind websocket_frame_deframer_top wsdf_checker u_wsdf_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_rx_byte      (s_rx_byte),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_payload_byte (m_payload_byte),
    .m_frame_opcode (m_frame_opcode),
    .m_has_byte     (m_has_byte),
    .m_frame_last   (m_frame_last)
);
